/* src/md5_stream_hash_core_defines.svh */
// Assertion macros for the hash core
`ifndef MD5_STREAM_HASH_CORE_DEFINES_SVH
`define MD5_STREAM_HASH_CORE_DEFINES_SVH

// Implication checked every clock, off during reset
`define MD5_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define MD5_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/md5_pkg.sv */
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
  } md5_out_t;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenOffset = 6'd56;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_idx(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'(5 * r[3:0] + 1);
      2'd2:    g = 4'(3 * r[3:0] + 5);
      default: g = 4'(7 * r[3:0]);
    endcase
    return g;
  endfunction

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_rnd_req_t;

endpackage

/* src/md5_stream_hash_core.sv */
// Channel | Dir | Handshake               | Payload
// in      | in  | in_valid_i / in_stall_o  | in_data_i  (md5_in_t)
// out     | out | out_valid_o / out_stall_i| out_data_o (md5_out_t)
// A byte without end is written to the buffer as it is taken; a 64th byte
// stalls the input while the block is compressed (one round per cycle,
// chaining add with the last round). An end item pads byte by byte and
// writes the length bytes, then the digest moves into the output register.
// Reset restores the initial chaining words; buffer contents are left as is.
// Input is stalled while padding, writing the length or compressing, and while
// a digest waits for the output register.
`include "md5_stream_hash_core_defines.svh"

module md5_stream_hash_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  md5_pkg::md5_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output md5_pkg::md5_out_t out_data_o
);
  import md5_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPad  = 5'b00010,
    StComp = 5'b00100,
    StLen  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e       state_q, state_d;
  logic [31:0]  ca_q, cb_q, cc_q, cd_q, ca_d, cb_d, cc_d, cd_d;
  logic [63:0]  cnt_q, cnt_d;
  logic [5:0]   fill_q, fill_d;
  logic         fin_q, fin_d;
  logic         pad_q, pad_d;
  logic         len_done_q, len_done_d;
  logic [2:0]   lb_q, lb_d;
  md5_out_t     out_q, out_d;
  logic         out_vld_q, out_vld_d;
  logic         acc, we;
  logic [7:0]   wdata;
  logic [31:0]  rword;
  logic [3:0]   ridx;
  logic         done;
  logic [127:0] sum;
  md5_rnd_req_t req;

  md5_buf u_buf (
    .clk_i(clk_i), .we_i(we), .waddr_i(fill_q), .wdata_i(wdata),
    .raddr_i(ridx), .rdata_o(rword)
  );

  md5_round u_rnd (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .word_i(rword),
    .word_idx_o(ridx), .done_o(done), .sum_o(sum)
  );

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = out_vld_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d = state_q;
    ca_d = ca_q; cb_d = cb_q; cc_d = cc_q; cd_d = cd_q;
    cnt_d = cnt_q; fill_d = fill_q; fin_d = fin_q; lb_d = lb_q;
    pad_d = pad_q; len_done_d = len_done_q;
    out_d = out_q; out_vld_d = out_vld_q;
    we = 1'b0; wdata = 8'h00;
    req = '{start: 1'b0, a: ca_q, b: cb_q, c: cc_q, d: cd_q};
    if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (in_data_i.has_byte) begin
            we = 1'b1; wdata = in_data_i.data_byte;
            cnt_d = cnt_q + 64'd8;
            fill_d = fill_q + 6'd1;
          end
          if (in_data_i.last) begin
            fin_d = 1'b1;
            pad_d = 1'b1;
          end
          if (in_data_i.has_byte && fill_q == 6'd63) begin
            req.start = 1'b1;
            state_d = StComp;
          end else if (in_data_i.last) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        we = 1'b1;
        wdata = fin_q ? PadByte : 8'h00;
        fin_d = 1'b0;
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          req.start = 1'b1;
          state_d = StComp;
        end else if (fill_q + 6'd1 == LenOffset) begin
          lb_d = '0;
          state_d = StLen;
        end
      end
      StLen: begin
        we = 1'b1;
        wdata = cnt_q[8 * lb_q +: 8];
        fill_d = fill_q + 6'd1;
        lb_d = lb_q + 3'd1;
        if (lb_q == 3'd7) begin
          req.start = 1'b1;
          len_done_d = 1'b1;
          state_d = StComp;
        end
      end
      StComp: begin
        if (done) begin
          ca_d = ca_q + sum[127:96];
          cb_d = cb_q + sum[95:64];
          cc_d = cc_q + sum[63:32];
          cd_d = cd_q + sum[31:0];
          if (len_done_q) state_d = StOut;
          else if (pad_q) state_d = StPad;
          else state_d = StIdle;
        end
      end
      StOut: begin
        if (!out_vld_q || !out_stall_i) begin
          out_d = '{digest_word0: ca_q, digest_word1: cb_q,
                    digest_word2: cc_q, digest_word3: cd_q};
          out_vld_d = 1'b1;
          ca_d = IvA; cb_d = IvB; cc_d = IvC; cd_d = IvD;
          cnt_d = '0; fill_d = '0; lb_d = '0; fin_d = 1'b0;
          pad_d = 1'b0; len_done_d = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ca_q <= IvA; cb_q <= IvB; cc_q <= IvC; cd_q <= IvD;
      cnt_q <= '0; fill_q <= '0; fin_q <= 1'b0; lb_q <= '0;
      pad_q <= 1'b0;
      len_done_q <= 1'b0;
      out_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ca_q <= ca_d; cb_q <= cb_d; cc_q <= cc_d; cd_q <= cd_d;
      cnt_q <= cnt_d; fill_q <= fill_d; fin_q <= fin_d; lb_q <= lb_d;
      pad_q <= pad_d;
      len_done_q <= len_done_d;
      out_q <= out_d;
      out_vld_q <= out_vld_d;
    end
  end

  `MD5_ASSERT_IMP(a_stall_busy, clk_i, rst_ni, state_q != StIdle, in_stall_o)
  `MD5_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_vld_q && out_stall_i, out_vld_q && $stable(out_q))
  `MD5_ASSERT_IMP(a_done_comp, clk_i, rst_ni, done, state_q == StComp)

endmodule

/* src/md5_round.sv */
module md5_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  md5_pkg::md5_rnd_req_t req_i,
  input  logic [31:0]          word_i,
  output logic [3:0]           word_idx_o,
  output logic                 done_o,
  output logic [127:0]         sum_o
);
  import md5_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [31:0] a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [31:0] f, t, rot;
  logic [4:0]  s;

  // word for the next round, read registered
  assign word_idx_o = msg_idx(rnd_d);
  assign s = rot_amt(rnd_q);

  always_comb begin
    case (rnd_q[5:4])
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    t = a_q + f + RoundK[rnd_q] + word_i;
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  always_comb begin
    busy_d = busy_q;
    rnd_d = rnd_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rnd_d = '0;
      a_d = req_i.a; b_d = req_i.b; c_d = req_i.c; d_d = req_i.d;
    end else if (busy_q) begin
      a_d = d_q;
      d_d = c_q;
      c_d = b_q;
      b_d = b_q + rot;
      rnd_d = rnd_q + 6'd1;
      if (rnd_q == 6'd63) busy_d = 1'b0;
    end
  end

  assign done_o = busy_q && (rnd_q == 6'd63);
  assign sum_o = {d_q, b_q + rot, b_q, c_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q <= '0;
    end else begin
      busy_q <= busy_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
  end

endmodule

/* src/md5_buf.sv */
module md5_buf (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [5:0]  waddr_i,
  input  logic [7:0]  wdata_i,
  input  logic [3:0]  raddr_i,
  output logic [31:0] rdata_o
);
  import md5_pkg::*;

  logic [31:0] mem [16];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i[5:2]][8 * waddr_i[1:0] +: 8] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
